// ===== rtl/word_tokenizer_stream_top_defines.svh =====
// Assertion macros shared by the tokenizer RTL.
`ifndef WORD_TOKENIZER_STREAM_TOP_DEFINES_SVH
`define WORD_TOKENIZER_STREAM_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define WTS_ASSERT(label, clk_s, rst_s, prop) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
        else $error("word tokenizer: invariant violated");

// Property that must hold in the cycle after a trigger.
`define WTS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("word tokenizer: sequence violated");

`else

`define WTS_ASSERT(label, clk_s, rst_s, prop)
`define WTS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons)

`endif

`endif

// ===== rtl/wts_pkg.sv =====
`default_nettype none

package wts_pkg;

    localparam int MAX_WORD_LEN_DEF = 64;

    // Character codes with special meaning
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_Z = 8'd90;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    // UTF-8 masks and patterns
    localparam logic [7:0] UTF8_HIGH_BIT  = 8'h80;
    localparam logic [7:0] UTF8_LEAD_MASK = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3_MASK = 8'hE0;
    localparam logic [7:0] UTF8_LEAD4_MASK = 8'hF8;
    localparam logic [7:0] UTF8_LEAD4_PAT  = 8'hF0;

    // Result kinds
    localparam logic KIND_WORD     = 1'b0;
    localparam logic KIND_LINE_END = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_TAIL
    } state_t;

    typedef enum logic [2:0] {
        CLS_LINE_END,
        CLS_IGNORE,
        CLS_SEP,
        CLS_PUNCT,
        CLS_WORD
    } byte_class_t;

    // What follows the drained word
    typedef enum logic [1:0] {
        SFX_NONE,
        SFX_PUNCT,
        SFX_LINE_END
    } suffix_t;

    function automatic logic is_punct(logic [7:0] c);
        return (c >= 8'd33  && c <= 8'd47)  || (c >= 8'd58  && c <= 8'd64) ||
               (c >= 8'd91  && c <= 8'd96)  || (c >= 8'd123 && c <= 8'd126);
    endfunction

    function automatic byte_class_t classify(logic [7:0] c, logic eoi);
        byte_class_t cls;
        if (eoi || c == CH_LF)
            cls = CLS_LINE_END;
        else if (c == CH_CR)
            cls = CLS_IGNORE;
        else if (c == CH_NUL || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_SPACE)
            cls = CLS_SEP;
        else if (is_punct(c))
            cls = CLS_PUNCT;
        else
            cls = CLS_WORD;
        return cls;
    endfunction

    function automatic logic [7:0] to_lower(logic [7:0] c);
        logic [7:0] r;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
            r = c + CASE_OFFSET;
        else
            r = c;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/wts_in_if.sv =====
`default_nettype none

interface wts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_input;

    modport source (output valid, output text_byte, output end_of_input, input ready);
    modport sink   (input valid, input text_byte, input end_of_input, output ready);
endinterface

`default_nettype wire

// ===== rtl/wts_out_if.sv =====
`default_nettype none

interface wts_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] word_byte;
    logic       last;

    modport source (output valid, output kind, output word_byte, output last, input ready);
    modport sink   (input valid, input kind, input word_byte, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/word_tokenizer_stream_top.sv =====
// Streaming word tokenizer.
// Channel text (sink) takes one byte or an end-of-input mark per transfer.
// Channel token (source) gives one result per transfer: a word byte
// (kind 0, lowercased, last set on the final byte) or a line end (kind 1).
// Word bytes are stored in a word buffer RAM as they are accepted. A byte
// that ends a word (separator, punctuation unless the word is full, newline,
// end of input) starts a drain: the RAM read is started, then the word
// bytes follow one per cycle while token accepts them, then a punctuation
// or line-end result, if any. While draining, text is not accepted.
// The result sits in an output register; when token stalls, the drain
// holds its place and resumes as soon as ready returns.
// Reset clears the word length, the drain state and the output register;
// the word buffer is not cleared (unwritten entries are never read).
// Words keep at most MAX_WORD_LEN-1 bytes; a full word ended by a
// separator or line end has a trailing partial UTF-8 sequence trimmed.
`default_nettype none

`include "word_tokenizer_stream_top_defines.svh"

module word_tokenizer_stream_top #(
    parameter int MAX_WORD_LEN = wts_pkg::MAX_WORD_LEN_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    wts_in_if.sink   text,
    wts_out_if.source token
);

    import wts_pkg::*;

    localparam int WORD_LIMIT = MAX_WORD_LEN - 1;
    localparam int ADDR_W     = $clog2(WORD_LIMIT);
    localparam int LEN_W      = $clog2(MAX_WORD_LEN);
    localparam logic [LEN_W-1:0] LIMIT_LEN = LEN_W'(WORD_LIMIT);

    state_t            state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  emit_len_reg, emit_len_next;
    logic [ADDR_W-1:0] byte_idx_reg, byte_idx_next;
    suffix_t           pend_reg, pend_next;
    logic [7:0]        pend_byte_reg, pend_byte_next;
    logic [7:0]        tail1_reg, tail1_next;
    logic [7:0]        tail2_reg, tail2_next;
    logic [7:0]        tail3_reg, tail3_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_kind_reg, out_kind_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;

    logic              in_fire;
    byte_class_t       in_cls;
    logic              word_full;
    logic              out_free;
    logic              last_byte;
    logic [LEN_W-1:0]  trim_len;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_rdata;

    wts_ram #(
        .WIDTH (8),
        .DEPTH (WORD_LIMIT)
    ) u_word_buf (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Handshake and decode
    assign text.ready = (state_reg == ST_IDLE);
    assign in_fire    = text.valid && text.ready;
    assign in_cls     = classify(text.text_byte, text.end_of_input);
    assign word_full  = (len_reg == LIMIT_LEN);
    assign out_free   = !out_valid_reg || token.ready;
    assign last_byte  = (LEN_W'(byte_idx_reg) == emit_len_reg - LEN_W'(1));

    // Trailing partial UTF-8 trim on a full word; tails hold the last three bytes
    always_comb
    begin
        trim_len = len_reg;
        if (word_full && (tail1_reg & UTF8_HIGH_BIT) == UTF8_HIGH_BIT)
        begin
            if ((tail1_reg & UTF8_LEAD_MASK) == UTF8_LEAD_MASK)
                trim_len = len_reg - LEN_W'(1);
            else if ((tail2_reg & UTF8_LEAD3_MASK) == UTF8_LEAD3_MASK)
                trim_len = len_reg - LEN_W'(2);
            else if ((tail3_reg & UTF8_LEAD4_MASK) == UTF8_LEAD4_PAT)
                trim_len = len_reg - LEN_W'(3);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_cls)
                        CLS_LINE_END: state_next = (len_reg != '0) ? ST_FETCH : ST_TAIL;
                        CLS_SEP:
                        begin
                            if (len_reg != '0)
                                state_next = ST_FETCH;
                        end
                        CLS_PUNCT:
                        begin
                            if (!word_full)
                                state_next = (len_reg != '0) ? ST_FETCH : ST_TAIL;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_FETCH: state_next = ST_LOAD;
            ST_LOAD:
            begin
                if (out_free && last_byte)
                    state_next = (pend_reg == SFX_NONE) ? ST_IDLE : ST_TAIL;
            end
            ST_TAIL:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and RAM control
    always_comb
    begin
        len_next       = len_reg;
        emit_len_next  = emit_len_reg;
        byte_idx_next  = byte_idx_reg;
        pend_next      = pend_reg;
        pend_byte_next = pend_byte_reg;
        tail1_next     = tail1_reg;
        tail2_next     = tail2_reg;
        tail3_next     = tail3_reg;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !token.ready;
        mem_we         = 1'b0;
        mem_waddr      = len_reg[ADDR_W-1:0];
        mem_wdata      = to_lower(text.text_byte);
        mem_re         = 1'b0;
        mem_raddr      = byte_idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_cls)
                        CLS_LINE_END:
                        begin
                            len_next      = '0;
                            pend_next     = SFX_LINE_END;
                            emit_len_next = trim_len;
                            byte_idx_next = '0;
                        end
                        CLS_SEP:
                        begin
                            len_next      = '0;
                            pend_next     = SFX_NONE;
                            emit_len_next = trim_len;
                            byte_idx_next = '0;
                        end
                        CLS_PUNCT:
                        begin
                            if (!word_full)
                            begin
                                len_next       = '0;
                                pend_next      = SFX_PUNCT;
                                pend_byte_next = text.text_byte;
                                emit_len_next  = len_reg;
                                byte_idx_next  = '0;
                            end
                        end
                        CLS_WORD:
                        begin
                            if (!word_full)
                            begin
                                mem_we     = 1'b1;
                                len_next   = len_reg + LEN_W'(1);
                                tail1_next = mem_wdata;
                                tail2_next = tail1_reg;
                                tail3_next = tail2_reg;
                            end
                        end
                        default: len_next = len_reg;
                    endcase
                end
            end
            ST_FETCH:
            begin
                mem_re = 1'b1;
            end
            ST_LOAD:
            begin
                // Load one word byte and prefetch the next
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_WORD;
                    out_byte_next  = mem_rdata;
                    out_last_next  = last_byte;
                    if (!last_byte)
                    begin
                        byte_idx_next = byte_idx_reg + ADDR_W'(1);
                        mem_re        = 1'b1;
                        mem_raddr     = byte_idx_reg + ADDR_W'(1);
                    end
                end
            end
            ST_TAIL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (pend_reg == SFX_LINE_END)
                    begin
                        out_kind_next = KIND_LINE_END;
                        out_byte_next = '0;
                    end
                    else
                    begin
                        out_kind_next = KIND_WORD;
                        out_byte_next = pend_byte_reg;
                    end
                end
            end
            default: out_valid_next = out_valid_reg;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            pend_reg      <= SFX_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        emit_len_reg  <= emit_len_next;
        byte_idx_reg  <= byte_idx_next;
        pend_byte_reg <= pend_byte_next;
        tail1_reg     <= tail1_next;
        tail2_reg     <= tail2_next;
        tail3_reg     <= tail3_next;
        out_kind_reg  <= out_kind_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
    end

    assign token.valid     = out_valid_reg;
    assign token.kind      = out_kind_reg;
    assign token.word_byte = out_byte_reg;
    assign token.last      = out_last_reg;

    // Checks
    `WTS_ASSERT(a_len_bound, clk, rst_n, len_reg <= LIMIT_LEN)
    `WTS_ASSERT(a_drain_idx, clk, rst_n,
        !(state_reg == ST_LOAD) || (LEN_W'(byte_idx_reg) < emit_len_reg))
    `WTS_ASSERT(a_drain_nonempty, clk, rst_n,
        !(state_reg == ST_FETCH || state_reg == ST_LOAD) || (emit_len_reg != '0))
    `WTS_ASSERT_NEXT(a_line_end_drain, clk, rst_n, in_fire && in_cls == CLS_LINE_END,
        (state_reg == ST_FETCH || state_reg == ST_TAIL) && pend_reg == SFX_LINE_END)

endmodule

`default_nettype wire

// ===== rtl/wts_ram.sv =====
`default_nettype none

module wts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port, registered read that holds while re is low
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== test/word_tokenizer_stream_top_test.sv =====
`timescale 1ns / 100ps

module word_tokenizer_stream_top_test;

    import wts_pkg::*;

    localparam int WORD_CAP     = MAX_WORD_LEN_DEF - 1;
    localparam int RANDOM_ITEMS = 224;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LINGER       = 80;

    // Opening sequence: {end_of_input, text_byte}
    localparam logic [8:0] OPENING [26] = '{
        {1'b0, "A"}, {1'b0, CH_CR}, {1'b0, "b"}, {1'b0, CH_SPACE},
        {1'b0, "["}, {1'b0, "Z"}, {1'b0, "@"},
        {1'b0, CH_NUL}, {1'b0, CH_VT}, {1'b0, CH_FF},
        {1'b0, CH_LF}, {1'b1, 8'hFF},
        {1'b0, 8'hFF}, {1'b0, 8'h80}, {1'b0, CH_LF},
        {1'b0, "x"}, {1'b0, CH_NUL}, {1'b0, "y"}, {1'b0, CH_TAB},
        {1'b0, "1"}, {1'b0, CH_VT}, {1'b0, "m"}, {1'b0, CH_FF},
        {1'b0, "~"}, {1'b0, "k"}, {1'b1, 8'h00}
    };

    typedef struct {
        logic       kind;
        logic [7:0] word_byte;
        logic       last;
    } token_t;

    // Word splitter prediction and token comparison
    class token_scoreboard;
        logic [7:0] word_store [WORD_CAP];
        int unsigned stored;
        token_t     due_q[$];
        int         errors;
        int         checked;
        int         line_ends;
        int         full_words;
        int         trimmed;

        static function byte_class_t sort_byte(logic [7:0] c, logic eoi);
            if (eoi || c == CH_LF)
                return CLS_LINE_END;
            if (c == CH_CR)
                return CLS_IGNORE;
            if (c == CH_NUL || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_SPACE)
                return CLS_SEP;
            if ((c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
                (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126))
                return CLS_PUNCT;
            return CLS_WORD;
        endfunction

        function void expect_token(logic k, logic [7:0] b, logic l);
            token_t t;
            t.kind = k;
            t.word_byte = b;
            t.last = l;
            due_q = {due_q, t};
        endfunction

        // Drop a partial UTF-8 tail from a word that hit the length cap
        function int unsigned trim_tail(int unsigned n);
            int unsigned m;
            m = n;
            if (n == WORD_CAP)
            begin
                full_words++;
                if ((word_store[n-1] & UTF8_HIGH_BIT) != 0)
                begin
                    if ((word_store[n-1] & UTF8_LEAD_MASK) == UTF8_LEAD_MASK)
                        m = n - 1;
                    else if ((word_store[n-2] & UTF8_LEAD3_MASK) == UTF8_LEAD3_MASK)
                        m = n - 2;
                    else if ((word_store[n-3] & UTF8_LEAD4_MASK) == UTF8_LEAD4_PAT)
                        m = n - 3;
                end
            end
            if (m != n)
                trimmed++;
            return m;
        endfunction

        function void flush_word(int unsigned n);
            for (int unsigned k = 0; k < n; k++)
                expect_token(KIND_WORD, word_store[k], k + 1 == n);
        endfunction

        // Accepted text transfer: update word state, queue the tokens it causes
        function void note_text(logic [7:0] c, logic eoi);
            byte_class_t cls;
            cls = sort_byte(c, eoi);
            case (cls)
                CLS_LINE_END:
                begin
                    if (stored != 0)
                        flush_word(trim_tail(stored));
                    expect_token(KIND_LINE_END, 8'h00, 1'b1);
                    stored = 0;
                end
                CLS_SEP:
                begin
                    if (stored != 0)
                        flush_word(trim_tail(stored));
                    stored = 0;
                end
                CLS_PUNCT:
                begin
                    // a full word swallows punctuation
                    if (stored < WORD_CAP)
                    begin
                        flush_word(stored);
                        expect_token(KIND_WORD, c, 1'b1);
                        stored = 0;
                    end
                end
                CLS_WORD:
                begin
                    if (stored < WORD_CAP)
                    begin
                        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
                            c = c + CASE_OFFSET;
                        word_store[stored] = c;
                        stored++;
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_token(logic k, logic [7:0] b, logic l);
            token_t want;
            checked++;
            if (due_q.size() == 0)
            begin
                errors++;
                $error("unexpected token transfer: kind %0d word_byte %02h last %0d", k, b, l);
                return;
            end
            want = due_q.pop_front();
            if (want.kind == KIND_LINE_END)
                line_ends++;
            if (k !== want.kind)
            begin
                errors++;
                $error("kind: expected %0d, actual %0d", want.kind, k);
            end
            if (b !== want.word_byte)
            begin
                errors++;
                $error("word_byte: expected %02h, actual %02h", want.word_byte, b);
            end
            if (l !== want.last)
            begin
                errors++;
                $error("last: expected %0d, actual %0d", want.last, l);
            end
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       text_valid = 1'b0;
    logic [7:0] text_byte = 8'h00;
    logic       text_eoi = 1'b0;
    logic       sink_ready = 1'b0;

    bit src_calm = 1'b0;
    bit sink_calm = 1'b0;
    int sink_wait = 0;
    int sent = 0;
    int long_words = 0;
    int cycles = 0;

    token_scoreboard board = new;

    wts_in_if  text();
    wts_out_if token();

    assign text.valid        = text_valid;
    assign text.text_byte    = text_byte;
    assign text.end_of_input = text_eoi;
    assign token.ready       = sink_ready;

    word_tokenizer_stream_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text),
        .token (token)
    );

    always #10 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int draw_wait(bit calm);
        return calm ? 0 : $urandom_range(0, 12);
    endfunction

    // Token side: check each transfer, then stall a random number of cycles
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (token.valid && sink_ready)
            begin
                board.check_token(token.kind, token.word_byte, token.last);
                sink_wait = draw_wait(sink_calm);
            end
            else if (sink_wait > 0)
                sink_wait--;
            sink_ready <= (sink_wait == 0);
        end
    end

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        if ($urandom_range(0, 1) == 1)
        begin
            if ($urandom_range(0, 1) == 1)
                c = 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
            else
                c = 8'($urandom_range(CH_UPPER_A + CASE_OFFSET, CH_UPPER_Z + CASE_OFFSET));
        end
        else
        begin
            c = 8'($urandom_range(0, 255));
            while (token_scoreboard::sort_byte(c, 1'b0) != CLS_WORD)
                c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    function automatic logic [7:0] punct_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (token_scoreboard::sort_byte(c, 1'b0) != CLS_PUNCT)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] cont_char();
        return UTF8_HIGH_BIT | 8'($urandom_range(0, 63));
    endfunction

    // One text transfer; valid stays high across back-to-back transfers
    task automatic send_text(input logic [7:0] c, input logic eoi);
        int gap;
        gap = draw_wait(src_calm);
        if (gap > 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_valid <= 1'b1;
        text_byte <= c;
        text_eoi <= eoi;
        @(posedge clk);
        while (!text.ready)
            @(posedge clk);
        board.note_text(c, eoi);
        sent++;
    endtask

    task automatic pause_until_drained();
        text_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // Short words with assorted separators and line endings
    task automatic send_sentence();
        int words;
        int len;
        int pick;
        words = $urandom_range(1, 6);
        for (int w = 0; w < words; w++)
        begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++)
            begin
                send_text(word_char(), 1'b0);
                if ($urandom_range(0, 15) == 0)
                    send_text(CH_CR, 1'b0);
            end
            pick = $urandom_range(0, 5);
            case (pick)
                0, 1: send_text(CH_SPACE, 1'b0);
                2: send_text(CH_TAB, 1'b0);
                3: send_text(punct_char(), 1'b0);
                4:
                begin
                    send_text(punct_char(), 1'b0);
                    send_text(CH_SPACE, 1'b0);
                end
                default:
                begin
                    pick = $urandom_range(0, 2);
                    send_text(pick == 0 ? CH_NUL : (pick == 1 ? CH_VT : CH_FF), 1'b0);
                end
            endcase
        end
        pick = $urandom_range(0, 3);
        case (pick)
            0: send_text(CH_LF, 1'b0);
            1: send_text(8'($urandom_range(0, 255)), 1'b1);
            2:
            begin
                send_text(CH_CR, 1'b0);
                send_text(CH_LF, 1'b0);
            end
            default:
            begin
            end
        endcase
    endtask

    // Word at or near the cap, with a shaped UTF-8 tail
    task automatic send_long_word();
        logic [7:0] tail [3];
        int len;
        int pattern;
        int extra;
        int pick;
        len = ($urandom_range(0, 2) == 0) ? $urandom_range(WORD_CAP - 5, WORD_CAP - 1)
                                          : WORD_CAP;
        pattern = long_words % 5;
        long_words++;
        tail[0] = word_char();
        tail[1] = word_char();
        tail[2] = word_char();
        case (pattern)
            0: tail[2] = UTF8_LEAD_MASK | 8'($urandom_range(0, 63));
            1:
            begin
                tail[1] = UTF8_LEAD3_MASK | 8'($urandom_range(0, 31));
                tail[2] = cont_char();
            end
            2:
            begin
                tail[0] = UTF8_LEAD4_PAT | 8'($urandom_range(0, 7));
                tail[1] = cont_char();
                tail[2] = cont_char();
            end
            3:
            begin
                // five-byte lead pattern must not trim
                tail[0] = UTF8_LEAD4_MASK | 8'($urandom_range(0, 7));
                tail[1] = cont_char();
                tail[2] = cont_char();
            end
            default:
            begin
            end
        endcase
        for (int k = 0; k < len - 3; k++)
            send_text(word_char(), 1'b0);
        for (int k = 0; k < 3; k++)
            send_text(tail[k], 1'b0);
        // bytes past the cap are dropped
        if (len == WORD_CAP)
        begin
            extra = $urandom_range(0, 4);
            for (int k = 0; k < extra; k++)
            begin
                pick = $urandom_range(0, 2);
                send_text(pick == 0 ? word_char() : (pick == 1 ? punct_char() : CH_CR), 1'b0);
            end
        end
        pick = $urandom_range(0, 4);
        case (pick)
            0: send_text(CH_SPACE, 1'b0);
            1: send_text(CH_LF, 1'b0);
            2: send_text(8'($urandom_range(0, 255)), 1'b1);
            3: send_text(CH_NUL, 1'b0);
            default:
            begin
                send_text(punct_char(), 1'b0);
                send_text(CH_SPACE, 1'b0);
            end
        endcase
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 10);
        for (int k = 0; k < n; k++)
            send_text(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
    endtask

    initial
    begin
        int pick;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corner cases
        foreach (OPENING[i])
            send_text(OPENING[i][7:0], OPENING[i][8]);
        pause_until_drained();

        // Random sequences, mostly well-formed text
        while (sent < $size(OPENING) + RANDOM_ITEMS)
        begin
            src_calm = ($urandom_range(0, 4) == 0);
            sink_calm = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 11);
            if (pick < 6)
                send_sentence();
            else if (pick < 8)
                send_long_word();
            else
                send_noise();
            if ($urandom_range(0, 9) == 0)
                pause_until_drained();
        end

        pause_until_drained();
        repeat (LINGER) @(posedge clk);

        $display("%0d text transfers, %0d tokens checked, %0d line ends", sent,
                 board.checked, board.line_ends);
        $display("%0d capped words closed by a separator, %0d with a UTF-8 tail trimmed",
                 board.full_words, board.trimmed);
        if (board.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
